[src/qrl_pkg.sv]
// qrl_pkg: shared types, field codes and neighbor tables for the quadtree refine link block
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package qrl_pkg;

  // table geometry
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned LINK_FIELDS    = 8;
  localparam int unsigned LINK_W         = 11;
  localparam int unsigned COUNT_W        = 12;

  // link value meaning no neighbor
  localparam logic [LINK_W-1:0] NONE_LINK = 11'h7FF;
  // leaves added by one refine
  localparam logic [COUNT_W-1:0] LEAF_STEP = 12'd4;

  typedef enum logic [1:0] {
    CMD_REFINE   = 2'd0,
    CMD_WR_LINK  = 2'd1,
    CMD_WR_FLAGS = 2'd2,
    CMD_RD_FIELD = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    FLD_LEVEL  = 3'd0,
    FLD_PARENT = 3'd1,
    FLD_FIRST  = 3'd2,
    FLD_SIB    = 3'd3,
    FLD_LEFT   = 3'd4,
    FLD_RIGHT  = 3'd5,
    FLD_DOWN   = 3'd6,
    FLD_UP     = 3'd7
  } fld_e;

  // block index driving the link memory address
  typedef enum logic [1:0] {
    BS_NB    = 2'd0,
    BS_SON   = 2'd1,
    BS_RDATA = 2'd2,
    BS_NEIGH = 2'd3
  } blk_sel_e;

  // source of link write data
  typedef enum logic [2:0] {
    DS_FVAL  = 3'd0,
    DS_LEV   = 3'd1,
    DS_NB    = 3'd2,
    DS_SIB   = 3'd3,
    DS_CHILD = 3'd4,
    DS_OUTER = 3'd5,
    DS_SON   = 3'd6
  } dat_sel_e;

  typedef enum logic [2:0] {
    FL_NONE      = 3'd0,
    FL_CLEAR     = 3'd1,
    FL_RD_LINK   = 3'd2,
    FL_RD_NB     = 3'd3,
    FL_WR_IN     = 3'd4,
    FL_WR_PARENT = 3'd5,
    FL_WR_CHILD  = 3'd6
  } fl_op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEV_RD,
    ST_LEV_CAP,
    ST_SON_LEV,
    ST_SON_PAR,
    ST_SON_SIB,
    ST_SON_IN0,
    ST_SON_IN1,
    ST_OUT_RDN,
    ST_OUT_RDF,
    ST_OUT_WR1,
    ST_OUT_WR2,
    ST_FL_PAR,
    ST_FL_CHILD,
    ST_WR_LINK,
    ST_WR_FLAGS,
    ST_RD_ENTRY,
    ST_FL_RD,
    ST_EMIT
  } state_e;

  // controller to datapath command word
  typedef struct packed {
    logic       accept;
    logic       lk_rd;
    logic       lk_wr;
    blk_sel_e   blk_sel;
    logic       use_fsel;
    fld_e       fld;
    dat_sel_e   dat_sel;
    logic [1:0] son_k;
    logic [1:0] dchild;
    logic [1:0] off;
    logic       cap_lev;
    logic       cap_n;
    logic       cap_s;
    fl_op_e     fl_op;
    logic       cnt_add;
    logic       out_load;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic inherit;
    logic clr_last;
    logic slot_free;
  } status_t;

  typedef struct packed {
    fld_e       fld;
    logic [1:0] child;
  } inner_t;

  typedef struct packed {
    fld_e       dir;
    logic [1:0] off;
    fld_e       back;
  } outer_t;

  // internal sibling link j of son k
  function automatic inner_t inner_link(input logic [1:0] k, input logic j);
    inner_t r;
    case ({k, j})
      3'b000:  r = '{fld: FLD_RIGHT, child: 2'd1};
      3'b001:  r = '{fld: FLD_UP,    child: 2'd2};
      3'b010:  r = '{fld: FLD_LEFT,  child: 2'd0};
      3'b011:  r = '{fld: FLD_UP,    child: 2'd3};
      3'b100:  r = '{fld: FLD_RIGHT, child: 2'd3};
      3'b101:  r = '{fld: FLD_DOWN,  child: 2'd0};
      3'b110:  r = '{fld: FLD_LEFT,  child: 2'd2};
      3'b111:  r = '{fld: FLD_DOWN,  child: 2'd1};
      default: r = '{fld: FLD_LEVEL, child: 2'd0};
    endcase
    return r;
  endfunction

  // outer side s of son k: direction, facing child offset, back link field
  function automatic outer_t outer_link(input logic [1:0] k, input logic s);
    outer_t r;
    case ({k, s})
      3'b000:  r = '{dir: FLD_LEFT,  off: 2'd1, back: FLD_RIGHT};
      3'b001:  r = '{dir: FLD_DOWN,  off: 2'd2, back: FLD_UP};
      3'b010:  r = '{dir: FLD_RIGHT, off: 2'd0, back: FLD_LEFT};
      3'b011:  r = '{dir: FLD_DOWN,  off: 2'd3, back: FLD_UP};
      3'b100:  r = '{dir: FLD_LEFT,  off: 2'd3, back: FLD_RIGHT};
      3'b101:  r = '{dir: FLD_UP,    off: 2'd0, back: FLD_DOWN};
      3'b110:  r = '{dir: FLD_RIGHT, off: 2'd2, back: FLD_LEFT};
      3'b111:  r = '{dir: FLD_UP,    off: 2'd1, back: FLD_DOWN};
      default: r = '{dir: FLD_LEVEL, off: 2'd0, back: FLD_LEVEL};
    endcase
    return r;
  endfunction

endpackage

[src/qrl_ifs.sv]
// qrl_in_if / qrl_out_if: valid-ready request and result channels
// no dependencies; used by the top level
`timescale 1ns / 1ps

interface qrl_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [9:0]        block;
  logic [9:0]        child_a;
  logic [9:0]        child_b;
  logic [9:0]        child_c;
  logic [9:0]        child_d;
  logic [2:0]        field_select;
  logic signed [10:0] field_value;
  logic              leaf_in;
  logic              refine_in;
  logic              coarsen_in;

  modport source (
    output valid, cmd, block, child_a, child_b, child_c, child_d,
           field_select, field_value, leaf_in, refine_in, coarsen_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, block, child_a, child_b, child_c, child_d,
           field_select, field_value, leaf_in, refine_in, coarsen_in,
    output ready
  );
endinterface

interface qrl_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] read_value;
  logic               leaf_out;
  logic               refine_out;
  logic               coarsen_out;
  logic [11:0]        leaf_total;

  modport source (
    output valid, read_value, leaf_out, refine_out, coarsen_out, leaf_total,
    input  ready
  );
  modport sink (
    input  valid, read_value, leaf_out, refine_out, coarsen_out, leaf_total,
    output ready
  );
endinterface

[src/qrl_ctrl.sv]
// qrl_ctrl: sequencer stepping each request through its table reads and writes
// depends on qrl_pkg
`timescale 1ns / 1ps

module qrl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_cmd_i,
  input  qrl_pkg::status_t stat_i,
  output logic             in_ready_o,
  output qrl_pkg::ctrl_t   ctrl_o
);
  import qrl_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       side_q, side_d;
  inner_t     inn0, inn1;
  outer_t     outr;

  assign inn0 = inner_link(k_q, 1'b0);
  assign inn1 = inner_link(k_q, 1'b1);
  assign outr = outer_link(k_q, side_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      k_q     <= 2'd0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      side_q  <= side_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    side_d  = side_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          k_d    = 2'd0;
          side_d = 1'b0;
          case (cmd_e'(in_cmd_i))
            CMD_REFINE:   state_d = ST_LEV_RD;
            CMD_WR_LINK:  state_d = ST_WR_LINK;
            CMD_WR_FLAGS: state_d = ST_WR_FLAGS;
            default:      state_d = ST_RD_ENTRY;
          endcase
        end
      end
      ST_LEV_RD:  state_d = ST_LEV_CAP;
      ST_LEV_CAP: state_d = ST_SON_LEV;
      ST_SON_LEV: state_d = ST_SON_PAR;
      ST_SON_PAR: state_d = ST_SON_SIB;
      ST_SON_SIB: state_d = ST_SON_IN0;
      ST_SON_IN0: state_d = ST_SON_IN1;
      ST_SON_IN1: state_d = ST_OUT_RDN;
      ST_OUT_RDN: state_d = ST_OUT_RDF;
      ST_OUT_RDF: state_d = ST_OUT_WR1;
      ST_OUT_WR1, ST_OUT_WR2: begin
        if (state_q == ST_OUT_WR1 && !stat_i.inherit) begin
          state_d = ST_OUT_WR2;
        end else if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_OUT_RDN;
        end else begin
          side_d = 1'b0;
          if (k_q == 2'd3) begin
            k_d     = 2'd0;
            state_d = ST_FL_PAR;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_SON_LEV;
          end
        end
      end
      ST_FL_PAR: begin
        k_d     = 2'd0;
        state_d = ST_FL_CHILD;
      end
      ST_FL_CHILD: begin
        if (k_q == 2'd3) begin
          k_d     = 2'd0;
          state_d = ST_FL_RD;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_WR_LINK:  state_d = ST_FL_RD;
      ST_WR_FLAGS: state_d = ST_FL_RD;
      ST_RD_ENTRY: state_d = ST_EMIT;
      ST_FL_RD:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    ctrl_o.son_k = k_q;
    case (state_q)
      ST_CLEAR: ctrl_o.fl_op = FL_CLEAR;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      ST_LEV_RD: begin
        ctrl_o.lk_rd   = 1'b1;
        ctrl_o.blk_sel = BS_NB;
        ctrl_o.fld     = FLD_LEVEL;
      end
      ST_LEV_CAP: ctrl_o.cap_lev = 1'b1;
      ST_SON_LEV: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = FLD_LEVEL;
        ctrl_o.dat_sel = DS_LEV;
      end
      ST_SON_PAR: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = FLD_PARENT;
        ctrl_o.dat_sel = DS_NB;
      end
      ST_SON_SIB: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = FLD_SIB;
        ctrl_o.dat_sel = DS_SIB;
      end
      ST_SON_IN0: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = inn0.fld;
        ctrl_o.dat_sel = DS_CHILD;
        ctrl_o.dchild  = inn0.child;
      end
      ST_SON_IN1: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = inn1.fld;
        ctrl_o.dat_sel = DS_CHILD;
        ctrl_o.dchild  = inn1.child;
      end
      ST_OUT_RDN: begin
        ctrl_o.lk_rd   = 1'b1;
        ctrl_o.blk_sel = BS_NB;
        ctrl_o.fld     = outr.dir;
      end
      ST_OUT_RDF: begin
        ctrl_o.lk_rd   = 1'b1;
        ctrl_o.blk_sel = BS_RDATA;
        ctrl_o.fld     = FLD_FIRST;
        ctrl_o.fl_op   = FL_RD_LINK;
        ctrl_o.cap_n   = 1'b1;
      end
      ST_OUT_WR1: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_SON;
        ctrl_o.fld     = outr.dir;
        ctrl_o.dat_sel = DS_OUTER;
        ctrl_o.off     = outr.off;
        ctrl_o.cap_s   = 1'b1;
      end
      ST_OUT_WR2: begin
        ctrl_o.lk_wr   = 1'b1;
        ctrl_o.blk_sel = BS_NEIGH;
        ctrl_o.fld     = outr.back;
        ctrl_o.dat_sel = DS_SON;
      end
      ST_FL_PAR: begin
        ctrl_o.fl_op   = FL_WR_PARENT;
        ctrl_o.cnt_add = 1'b1;
      end
      ST_FL_CHILD: ctrl_o.fl_op = FL_WR_CHILD;
      ST_WR_LINK: begin
        ctrl_o.lk_wr    = 1'b1;
        ctrl_o.blk_sel  = BS_NB;
        ctrl_o.use_fsel = 1'b1;
        ctrl_o.dat_sel  = DS_FVAL;
      end
      ST_WR_FLAGS: ctrl_o.fl_op = FL_WR_IN;
      ST_RD_ENTRY: begin
        ctrl_o.lk_rd    = 1'b1;
        ctrl_o.blk_sel  = BS_NB;
        ctrl_o.use_fsel = 1'b1;
        ctrl_o.fl_op    = FL_RD_NB;
      end
      ST_FL_RD: ctrl_o.fl_op = FL_RD_NB;
      ST_EMIT:  ctrl_o.out_load = stat_i.slot_free;
      default: ;
    endcase
  end

endmodule

[src/qrl_dp.sv]
// qrl_dp: link table memory, flag memories, leaf counter and result register
// depends on qrl_pkg; driven by qrl_ctrl
`timescale 1ns / 1ps

module qrl_dp #(
  parameter int unsigned MAX_BLOCKS = qrl_pkg::MAX_BLOCKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qrl_pkg::ctrl_t     ctrl_i,
  input  logic [1:0]         cmd_i,
  input  logic [9:0]         block_i,
  input  logic [9:0]         child_a_i,
  input  logic [9:0]         child_b_i,
  input  logic [9:0]         child_c_i,
  input  logic [9:0]         child_d_i,
  input  logic [2:0]         field_select_i,
  input  logic signed [10:0] field_value_i,
  input  logic               leaf_in_i,
  input  logic               refine_in_i,
  input  logic               coarsen_in_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [10:0] read_value_o,
  output logic               leaf_out_o,
  output logic               refine_out_o,
  output logic               coarsen_out_o,
  output logic [11:0]        leaf_total_o,
  output qrl_pkg::status_t   stat_o
);
  import qrl_pkg::*;

  // MAX_BLOCKS must be a power of two (the block itself does not enforce it): block indices wrap by truncation
  localparam int unsigned BW    = $clog2(MAX_BLOCKS);
  localparam int unsigned XW    = (BW > LINK_W) ? BW : LINK_W;
  localparam int unsigned DEPTH = MAX_BLOCKS * LINK_FIELDS;
  localparam int unsigned AW    = BW + $clog2(LINK_FIELDS);

  function automatic logic [BW-1:0] blk_of(input logic [LINK_W-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[BW-1:0];
  endfunction

  function automatic logic [LINK_W-1:0] link_of(input logic [BW-1:0] b);
    logic [XW-1:0] t;
    t = XW'(b);
    return t[LINK_W-1:0];
  endfunction

  // latched request
  cmd_e              cmd_q;
  logic [BW-1:0]     nb_q, ch_a_q, ch_b_q, ch_c_q, ch_d_q;
  logic [2:0]        fsel_q;
  logic [LINK_W-1:0] fval_q;
  logic              lin_q, rin_q, cin_q;

  // working registers
  logic [LINK_W-1:0] lev_q, n_q, s_q, lk_rdata_q;
  logic              leaf_rd_q, ref_rd_q, coa_rd_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [BW-1:0]     clr_addr_q;

  // result register
  logic               out_valid_q;
  logic [LINK_W-1:0]  out_rv_q;
  logic               out_leaf_q, out_ref_q, out_coa_q;
  logic [COUNT_W-1:0] out_cnt_q;

  logic [LINK_W-1:0] link_mem [DEPTH];
  logic              leaf_mem [MAX_BLOCKS];
  logic              ref_mem  [MAX_BLOCKS];
  logic              coa_mem  [MAX_BLOCKS];

  function automatic logic [BW-1:0] pick(input logic [1:0] sel, input logic [BW-1:0] a,
                                         input logic [BW-1:0] b, input logic [BW-1:0] c,
                                         input logic [BW-1:0] d);
    logic [BW-1:0] r;
    case (sel)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = c;
      default: r = d;
    endcase
    return r;
  endfunction

  logic [BW-1:0]     son_idx, dch_idx, lk_blk, fl_addr;
  logic [2:0]        lk_fld;
  logic [AW-1:0]     lk_addr;
  logic [LINK_W-1:0] facing, lk_wdata;
  logic              inherit;
  logic              fl_rd, wr_leaf, wr_ref, wr_coa;
  logic              leaf_wd, ref_wd, coa_wd;

  assign son_idx = pick(ctrl_i.son_k, ch_a_q, ch_b_q, ch_c_q, ch_d_q);
  assign dch_idx = pick(ctrl_i.dchild, ch_a_q, ch_b_q, ch_c_q, ch_d_q);
  assign facing  = lk_rdata_q + LINK_W'(ctrl_i.off);
  // neighbor absent or not refined: keep the coarse link
  assign inherit = (n_q == NONE_LINK) || leaf_rd_q;

  always_comb begin
    case (ctrl_i.blk_sel)
      BS_NB:    lk_blk = nb_q;
      BS_SON:   lk_blk = son_idx;
      BS_RDATA: lk_blk = blk_of(lk_rdata_q);
      default:  lk_blk = blk_of(s_q);
    endcase
  end

  assign lk_fld  = ctrl_i.use_fsel ? fsel_q : ctrl_i.fld;
  assign lk_addr = {lk_blk, lk_fld};

  always_comb begin
    case (ctrl_i.dat_sel)
      DS_FVAL:  lk_wdata = fval_q;
      DS_LEV:   lk_wdata = lev_q;
      DS_NB:    lk_wdata = link_of(nb_q);
      DS_SIB:   lk_wdata = LINK_W'(ctrl_i.son_k);
      DS_CHILD: lk_wdata = link_of(dch_idx);
      DS_OUTER: lk_wdata = inherit ? n_q : facing;
      default:  lk_wdata = link_of(son_idx);
    endcase
  end

  // flag memory port
  always_comb begin
    fl_addr = nb_q;
    fl_rd   = 1'b0;
    wr_leaf = 1'b0;
    wr_ref  = 1'b0;
    wr_coa  = 1'b0;
    leaf_wd = 1'b0;
    ref_wd  = 1'b0;
    coa_wd  = 1'b0;
    case (ctrl_i.fl_op)
      FL_CLEAR: begin
        fl_addr = clr_addr_q;
        wr_leaf = 1'b1;
        wr_ref  = 1'b1;
        wr_coa  = 1'b1;
      end
      FL_RD_LINK: begin
        fl_addr = blk_of(lk_rdata_q);
        fl_rd   = 1'b1;
      end
      FL_RD_NB: fl_rd = 1'b1;
      FL_WR_IN: begin
        wr_leaf = 1'b1;
        wr_ref  = 1'b1;
        wr_coa  = 1'b1;
        leaf_wd = lin_q;
        ref_wd  = rin_q;
        coa_wd  = cin_q;
      end
      FL_WR_PARENT: begin
        wr_leaf = 1'b1;
        wr_ref  = 1'b1;
        wr_coa  = 1'b1;
      end
      FL_WR_CHILD: begin
        fl_addr = son_idx;
        wr_leaf = 1'b1;
        wr_coa  = 1'b1;
        leaf_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lk_wr) link_mem[lk_addr] <= lk_wdata;
    if (ctrl_i.lk_rd) lk_rdata_q <= link_mem[lk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_leaf) leaf_mem[fl_addr] <= leaf_wd;
    if (wr_ref)  ref_mem[fl_addr]  <= ref_wd;
    if (wr_coa)  coa_mem[fl_addr]  <= coa_wd;
    if (fl_rd) begin
      leaf_rd_q <= leaf_mem[fl_addr];
      ref_rd_q  <= ref_mem[fl_addr];
      coa_rd_q  <= coa_mem[fl_addr];
    end
  end

  // request latch and working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      nb_q   <= blk_of({1'b0, block_i});
      ch_a_q <= blk_of({1'b0, child_a_i});
      ch_b_q <= blk_of({1'b0, child_b_i});
      ch_c_q <= blk_of({1'b0, child_c_i});
      ch_d_q <= blk_of({1'b0, child_d_i});
      fsel_q <= field_select_i;
      fval_q <= field_value_i;
      lin_q  <= leaf_in_i;
      rin_q  <= refine_in_i;
      cin_q  <= coarsen_in_i;
    end
    if (ctrl_i.cap_lev) lev_q <= lk_rdata_q + LINK_W'(1);
    if (ctrl_i.cap_n)   n_q   <= lk_rdata_q;
    if (ctrl_i.cap_s)   s_q   <= facing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      clr_addr_q <= '0;
    end else begin
      if (ctrl_i.cnt_add) cnt_q <= cnt_q + LEAF_STEP;
      if (ctrl_i.fl_op == FL_CLEAR) clr_addr_q <= clr_addr_q + BW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_rv_q   <= (cmd_q == CMD_RD_FIELD) ? lk_rdata_q : '0;
      out_leaf_q <= leaf_rd_q;
      out_ref_q  <= ref_rd_q;
      out_coa_q  <= coa_rd_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = $signed(out_rv_q);
  assign leaf_out_o    = out_leaf_q;
  assign refine_out_o  = out_ref_q;
  assign coarsen_out_o = out_coa_q;
  assign leaf_total_o  = out_cnt_q;

  assign stat_o.inherit   = inherit;
  assign stat_o.clr_last  = (clr_addr_q == BW'(MAX_BLOCKS - 1));
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

endmodule

[src/quadtree_refine_link_update.sv]
// quadtree_refine_link_update: top level joining the sequencer and the table datapath
// depends on qrl_pkg, qrl_ifs, qrl_ctrl and qrl_dp
`timescale 1ns / 1ps

// Quadtree mesh link table. Requests arrive on req_i (valid/ready), one result
// per request leaves on rsp_o (valid/ready), in request order.
//   cmd refine      : turns block into the parent of child_a..child_d, fills in the
//                     children's links and back links, updates flags, leaf count +4
//   cmd write link  : writes field_value into link field field_select of block
//   cmd write flags : writes leaf_in, refine_in, coarsen_in for block
//   cmd read field  : returns link field field_select of block in read_value
// Every result carries the block's flags and the leaf count after the request.
// The next request can be taken in the cycle after the result is loaded.
// The link memory has a single port: every link read and write of a refine
// goes through it, one per cycle.
// Reset: the flag memories are cleared one entry a cycle with req_i.ready
// low; link entries stay undefined until written.
// A stalled receiver holds the result in the output register; one more request
// is accepted and worked on, then the block waits until the result is taken.

module quadtree_refine_link_update #(
  parameter int unsigned MAX_BLOCKS = qrl_pkg::MAX_BLOCKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrl_in_if.sink     req_i,
  qrl_out_if.source  rsp_o
);
  import qrl_pkg::*;

  ctrl_t   ctrl;
  status_t stat;
  logic    in_ready;

  // sequencer: one request at a time
  qrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_cmd_i   (req_i.cmd),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  assign req_i.ready = in_ready;

  // table storage, working registers and result register
  qrl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (req_i.cmd),
    .block_i        (req_i.block),
    .child_a_i      (req_i.child_a),
    .child_b_i      (req_i.child_b),
    .child_c_i      (req_i.child_c),
    .child_d_i      (req_i.child_d),
    .field_select_i (req_i.field_select),
    .field_value_i  (req_i.field_value),
    .leaf_in_i      (req_i.leaf_in),
    .refine_in_i    (req_i.refine_in),
    .coarsen_in_i   (req_i.coarsen_in),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .read_value_o   (rsp_o.read_value),
    .leaf_out_o     (rsp_o.leaf_out),
    .refine_out_o   (rsp_o.refine_out),
    .coarsen_out_o  (rsp_o.coarsen_out),
    .leaf_total_o   (rsp_o.leaf_total),
    .stat_o         (stat)
  );

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result loaded over pending result");

  // an accepted request closes the input until its work is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in work");

  // no table write while the block waits for a request
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!ctrl.lk_wr && ctrl.fl_op == FL_NONE))
    else $error("table written while idle");

endmodule

[test/qrl_link_checker.sv]
// qrl_link_checker: watches both channels of the quadtree link block, keeps its own link
// table, flags and leaf count, and compares every result with the oldest one predicted
// depends on qrl_pkg and qrl_ifs
`timescale 1ns / 1ps

module qrl_link_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrl_in_if           req_i,
  qrl_out_if          rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import qrl_pkg::*;

  localparam int unsigned BLK_W = $clog2(MAX_BLOCKS_DEF);

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    link_t              value;
    logic               leaf;
    logic               refine;
    logic               coarsen;
    logic [COUNT_W-1:0] total;
  } result_t;

  link_t              link_mem    [0:LINK_FIELDS*MAX_BLOCKS_DEF-1];
  logic               leaf_mem    [0:MAX_BLOCKS_DEF-1];
  logic               refine_mem  [0:MAX_BLOCKS_DEF-1];
  logic               coarsen_mem [0:MAX_BLOCKS_DEF-1];
  logic [COUNT_W-1:0] leaf_count;
  result_t            awaited_results [$];
  int unsigned        mismatches = 0;

  function automatic link_t link_get(blk_t b, fld_e f);
    return link_mem[{b, f}];
  endfunction

  function automatic void link_put(blk_t b, fld_e f, link_t v);
    link_mem[{b, f}] = v;
  endfunction

  // outer side of a son: keep the coarse link unless the neighbor is refined,
  // then point at its facing child and write the back link there
  function automatic void outer_side(blk_t nb, blk_t son, fld_e dir, link_t off, fld_e back);
    link_t n;
    link_t s;
    link_t son_link;
    son_link = link_t'(son);
    n = link_get(nb, dir);
    if (n == NONE_LINK || leaf_mem[n[BLK_W-1:0]]) begin
      link_put(son, dir, n);
    end else begin
      s = link_get(n[BLK_W-1:0], FLD_FIRST) + off;
      link_put(son, dir, s);
      link_put(s[BLK_W-1:0], back, son_link);
    end
  endfunction

  function automatic void son_common(blk_t son, link_t lev, blk_t nb, link_t sib);
    link_put(son, FLD_LEVEL, lev);
    link_put(son, FLD_PARENT, link_t'(nb));
    link_put(son, FLD_SIB, sib);
  endfunction

  // writes fall in a fixed order so aliased children overwrite one another
  function automatic void refine_block(blk_t nb, blk_t ca, blk_t cb, blk_t cc, blk_t cd);
    link_t lev;
    lev = link_get(nb, FLD_LEVEL) + 1'b1;

    son_common(ca, lev, nb, 0);
    link_put(ca, FLD_RIGHT, link_t'(cb));
    link_put(ca, FLD_UP, link_t'(cc));
    outer_side(nb, ca, FLD_LEFT, 1, FLD_RIGHT);
    outer_side(nb, ca, FLD_DOWN, 2, FLD_UP);

    son_common(cb, lev, nb, 1);
    link_put(cb, FLD_LEFT, link_t'(ca));
    link_put(cb, FLD_UP, link_t'(cd));
    outer_side(nb, cb, FLD_RIGHT, 0, FLD_LEFT);
    outer_side(nb, cb, FLD_DOWN, 3, FLD_UP);

    son_common(cc, lev, nb, 2);
    link_put(cc, FLD_RIGHT, link_t'(cd));
    link_put(cc, FLD_DOWN, link_t'(ca));
    outer_side(nb, cc, FLD_LEFT, 3, FLD_RIGHT);
    outer_side(nb, cc, FLD_UP, 0, FLD_DOWN);

    son_common(cd, lev, nb, 3);
    link_put(cd, FLD_LEFT, link_t'(cc));
    link_put(cd, FLD_DOWN, link_t'(cb));
    outer_side(nb, cd, FLD_RIGHT, 2, FLD_LEFT);
    outer_side(nb, cd, FLD_UP, 1, FLD_DOWN);

    leaf_mem[nb] = 1'b0;
    leaf_mem[ca] = 1'b1;
    leaf_mem[cb] = 1'b1;
    leaf_mem[cc] = 1'b1;
    leaf_mem[cd] = 1'b1;
    leaf_count   = leaf_count + LEAF_STEP;

    refine_mem[nb]  = 1'b0;
    coarsen_mem[nb] = 1'b0;
    coarsen_mem[ca] = 1'b0;
    coarsen_mem[cb] = 1'b0;
    coarsen_mem[cc] = 1'b0;
    coarsen_mem[cd] = 1'b0;
  endfunction

  // applies one request to the table copy and returns the result it should give
  function automatic result_t table_response(cmd_e cmd, blk_t nb, blk_t ca, blk_t cb,
                                             blk_t cc, blk_t cd, fld_e fsel, link_t fval,
                                             logic lf, logic rf, logic cf);
    result_t r;
    r.value = '0;
    case (cmd)
      CMD_REFINE:   refine_block(nb, ca, cb, cc, cd);
      CMD_WR_LINK:  link_put(nb, fsel, fval);
      CMD_WR_FLAGS: begin
        leaf_mem[nb]    = lf;
        refine_mem[nb]  = rf;
        coarsen_mem[nb] = cf;
      end
      default:      r.value = link_get(nb, fsel);
    endcase
    r.leaf    = leaf_mem[nb];
    r.refine  = refine_mem[nb];
    r.coarsen = coarsen_mem[nb];
    r.total   = leaf_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BLOCKS_DEF; i++) begin
        leaf_mem[i]    = 1'b0;
        refine_mem[i]  = 1'b0;
        coarsen_mem[i] = 1'b0;
      end
      leaf_count = '0;
      awaited_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // results first, so a request taken on the same edge is not popped by mistake
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{value: rsp_i.read_value, leaf: rsp_i.leaf_out, refine: rsp_i.refine_out,
                coarsen: rsp_i.coarsen_out, total: rsp_i.leaf_total};
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited, leaf_total", got.total, '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.value !== want.value) begin
            report_mismatch("read_value", COUNT_W'(got.value), COUNT_W'(want.value));
          end
          if (got.leaf !== want.leaf) begin
            report_mismatch("leaf_out", COUNT_W'(got.leaf), COUNT_W'(want.leaf));
          end
          if (got.refine !== want.refine) begin
            report_mismatch("refine_out", COUNT_W'(got.refine), COUNT_W'(want.refine));
          end
          if (got.coarsen !== want.coarsen) begin
            report_mismatch("coarsen_out", COUNT_W'(got.coarsen), COUNT_W'(want.coarsen));
          end
          if (got.total !== want.total)     report_mismatch("leaf_total", got.total, want.total);
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_results.push_back(table_response(cmd_e'(req_i.cmd), req_i.block,
                                                 req_i.child_a, req_i.child_b,
                                                 req_i.child_c, req_i.child_d,
                                                 fld_e'(req_i.field_select),
                                                 req_i.field_value, req_i.leaf_in,
                                                 req_i.refine_in, req_i.coarsen_in));
      end
      errors_o  <= mismatches;
      pending_o <= awaited_results.size();
    end
  end

endmodule

[test/testbench.sv]
// testbench: top of the quadtree link block test; loads every link entry the traffic can
// reach, runs directed and random requests with gaps and stalls, and prints the verdict
// depends on qrl_pkg, qrl_ifs, qrl_link_checker and quadtree_refine_link_update
`timescale 1ns / 1ps

module testbench;
  import qrl_pkg::*;

  localparam int unsigned BLK_W        = $clog2(MAX_BLOCKS_DEF);
  localparam int unsigned POOL_TOP     = 63;    // most traffic stays in a small neighborhood
  // facing children of pool first-child links land up to three past the pool
  localparam int unsigned LOAD_TOP     = POOL_TOP + 3;
  // the two top blocks, reached through first-child links of none and -2
  localparam int unsigned HIGH_LOADS   = 2;
  localparam int unsigned LOAD_BLOCKS  = LOAD_TOP + 1 + HIGH_LOADS;
  localparam int unsigned LOAD_ITEMS   = LOAD_BLOCKS * (LINK_FIELDS + 1);
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned CALM_ITEMS   = 300;   // tail of the run without gaps or stalls
  localparam int unsigned HOLD_AT      = 300;   // random request at which the long hold starts
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 80;    // beyond the longest refine
  // worst case per request: slowest refine, longest stall and longest gap
  localparam longint unsigned CYCLE_LIMIT =
    3 * ((LOAD_ITEMS + 32 + RANDOM_ITEMS) * 70 + MAX_BLOCKS_DEF + HOLD_CYCLES + DRAIN_CYCLES);

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [LINK_W-1:0] link_t;

  // sign bit and low pool bits: negative patterns that wrap back into the pool
  localparam link_t WRAP_MASK = 11'h43F;

  typedef struct packed {
    cmd_e  cmd;
    blk_t  block;
    blk_t  child_a;
    blk_t  child_b;
    blk_t  child_c;
    blk_t  child_d;
    fld_e  field_select;
    link_t field_value;
    logic  leaf_in;
    logic  refine_in;
    logic  coarsen_in;
  } request_t;

  logic            clk;
  logic            rst_n;
  logic            idle_enable;   // random gaps and stalls allowed
  logic            hold_go;       // asks the result side for its one long hold
  int unsigned     errors;
  int unsigned     pending;
  longint unsigned cycle_count = 0;

  qrl_in_if  req ();
  qrl_out_if rsp ();

  quadtree_refine_link_update dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  qrl_link_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req),
    .rsp_i     (rsp),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // guard against a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // fully random payload, every bit of every field free
  function automatic request_t random_payload();
    request_t r;
    r.cmd          = cmd_e'($urandom_range(0, 3));
    r.block        = blk_t'($urandom());
    r.child_a      = blk_t'($urandom());
    r.child_b      = blk_t'($urandom());
    r.child_c      = blk_t'($urandom());
    r.child_d      = blk_t'($urandom());
    r.field_select = fld_e'($urandom_range(0, 7));
    r.field_value  = link_t'($urandom());
    r.leaf_in      = 1'($urandom_range(0, 1));
    r.refine_in    = 1'($urandom_range(0, 1));
    r.coarsen_in   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // mostly inside the pool so refines meet refined neighbors, now and then a top block
  function automatic blk_t pick_block();
    if ($urandom_range(0, 19) != 0) return blk_t'($urandom_range(0, POOL_TOP));
    return blk_t'(MAX_BLOCKS_DEF - 1 - $urandom_range(0, 1));
  endfunction

  // neighbor link: none, a pool block, or a pool block behind a negative pattern
  function automatic link_t pick_link();
    case ($urandom_range(0, 9))
      0, 1:          return NONE_LINK;
      2, 3, 4, 5, 6: return link_t'($urandom_range(0, POOL_TOP));
      default:       return link_t'($urandom()) & WRAP_MASK;
    endcase
  endfunction

  function automatic link_t load_value(fld_e f);
    case (f)
      FLD_LEVEL, FLD_PARENT, FLD_SIB: return link_t'($urandom());
      default:   return pick_link();
    endcase
  endfunction

  function automatic request_t item(cmd_e c, blk_t b, fld_e f, link_t v);
    request_t r;
    r              = random_payload();
    r.cmd          = c;
    r.block        = b;
    r.field_select = f;
    r.field_value  = v;
    return r;
  endfunction

  function automatic request_t refine_of(blk_t b, blk_t ca, blk_t cb, blk_t cc, blk_t cd);
    request_t r;
    r         = item(CMD_REFINE, b, fld_e'($urandom_range(0, 7)), link_t'($urandom()));
    r.child_a = ca;
    r.child_b = cb;
    r.child_c = cc;
    r.child_d = cd;
    return r;
  endfunction

  function automatic request_t flags_of(blk_t b, logic lf, logic rf, logic cf);
    request_t r;
    r            = item(CMD_WR_FLAGS, b, fld_e'($urandom_range(0, 7)), link_t'($urandom()));
    r.leaf_in    = lf;
    r.refine_in  = rf;
    r.coarsen_in = cf;
    return r;
  endfunction

  // random traffic: refines dominate the mix
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r    = random_payload();
    pick = $urandom_range(0, 99);
    if (pick < 55)      r.cmd = CMD_REFINE;
    else if (pick < 70) r.cmd = CMD_WR_LINK;
    else if (pick < 80) r.cmd = CMD_WR_FLAGS;
    else                r.cmd = CMD_RD_FIELD;
    r.block       = pick_block();
    r.child_a     = pick_block();
    r.child_b     = pick_block();
    r.child_c     = pick_block();
    r.child_d     = pick_block();
    r.field_value = pick_link();
    // children aliased with each other or with the parent
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       r.child_b = r.child_a;
        1:       r.child_d = r.block;
        default: begin
          r.child_c = r.child_a;
          r.child_a = r.block;
        end
      endcase
    end
    return r;
  endfunction

  // one request: optional gap, then hold valid until the block takes it
  task automatic send(input request_t r);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= r.cmd;
    req.block        <= r.block;
    req.child_a      <= r.child_a;
    req.child_b      <= r.child_b;
    req.child_c      <= r.child_c;
    req.child_d      <= r.child_d;
    req.field_select <= r.field_select;
    req.field_value  <= r.field_value;
    req.leaf_in      <= r.leaf_in;
    req.refine_in    <= r.refine_in;
    req.coarsen_in   <= r.coarsen_in;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  // result side: short random stalls, one long hold on request, steady ready otherwise
  initial begin : result_pacing
    bit hold_done;
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        // long hold so the output register fills and the request side backs up
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    request_t r;
    rst_n            <= 1'b0;
    idle_enable      <= 1'b1;
    hold_go          <= 1'b0;
    req.valid        <= 1'b0;
    req.cmd          <= CMD_RD_FIELD;
    req.block        <= '0;
    req.child_a      <= '0;
    req.child_b      <= '0;
    req.child_c      <= '0;
    req.child_d      <= '0;
    req.field_select <= FLD_LEVEL;
    req.field_value  <= '0;
    req.leaf_in      <= 1'b0;
    req.refine_in    <= 1'b0;
    req.coarsen_in   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // table load: every link entry the traffic can reach is written before anything
    // reads it, plus random leaf flags so both inherited and facing-child links show up
    // (the first request waits out the flag clearing pass)
    for (int n = 0; n < LOAD_BLOCKS; n++) begin
      blk_t b;
      b = (n <= int'(LOAD_TOP)) ? blk_t'(n) : blk_t'(MAX_BLOCKS_DEF - LOAD_BLOCKS + n);
      for (int f = 0; f < LINK_FIELDS; f++) begin
        r = item(CMD_WR_LINK, b, fld_e'(f), load_value(fld_e'(f)));
        send(r);
      end
      send(flags_of(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
    end

    // flags at both ends of the index range
    send(flags_of(0, 1'b1, 1'b1, 1'b1));
    send(flags_of(blk_t'(MAX_BLOCKS_DEF - 1), 1'b1, 1'b1, 1'b1));
    send(item(CMD_RD_FIELD, blk_t'(MAX_BLOCKS_DEF - 1), FLD_UP, '0));
    // no neighbor and the most negative link value
    send(item(CMD_WR_LINK, blk_t'(MAX_BLOCKS_DEF - 1), FLD_UP, NONE_LINK));
    send(item(CMD_WR_LINK, 0, FLD_LEFT, link_t'(11'h400)));
    send(item(CMD_RD_FIELD, 0, FLD_LEFT, '0));
    // refine the top index into the lowest children
    send(refine_of(blk_t'(MAX_BLOCKS_DEF - 1), 0, 1, 2, 3));
    send(item(CMD_RD_FIELD, 0, FLD_LEVEL, '0));
    // refined neighbor whose first child is -2: facing child comes out as none
    send(item(CMD_WR_LINK, 10, FLD_LEFT, 20));
    send(flags_of(20, 1'b0, 1'b0, 1'b0));
    send(item(CMD_WR_LINK, 20, FLD_FIRST, link_t'(11'h7FE)));
    send(refine_of(10, 11, 12, 13, 14));
    send(item(CMD_RD_FIELD, 11, FLD_LEFT, '0));
    // leaf neighbor: coarse link inherited
    send(item(CMD_WR_LINK, 30, FLD_DOWN, 31));
    send(flags_of(31, 1'b1, 1'b0, 1'b0));
    send(refine_of(30, 32, 33, 34, 35));
    send(item(CMD_RD_FIELD, 32, FLD_DOWN, '0));
    // child level wraps past the 11-bit limit
    send(item(CMD_WR_LINK, 50, FLD_LEVEL, NONE_LINK));
    send(refine_of(50, 51, 52, 53, 54));
    send(item(CMD_RD_FIELD, 51, FLD_LEVEL, '0));
    // negative link other than none addresses a wrapped block
    send(item(CMD_WR_LINK, 60, FLD_RIGHT, link_t'(-11'sd1000)));
    send(refine_of(60, 61, 62, 63, 64));
    // children aliased with each other and with the parent
    send(refine_of(40, 40, 40, 41, 41));
    send(item(CMD_RD_FIELD, 40, FLD_RIGHT, '0));

    // random traffic, long hold early on, calm tail at the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_go <= 1'b1;
      if (i == RANDOM_ITEMS - CALM_ITEMS) idle_enable <= 1'b0;
      send(random_request());
    end
    req.valid <= 1'b0;

    // let every awaited result come back, then a little longer
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
